>>> rtl/core/sus_pkg.sv
`timescale 1ns / 1ps
package sus_pkg;

	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int ECNT_W = 5;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DUP    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic srch_rd;
		logic srch_cmp;
		logic sh_init;
		logic sh_rd;
		logic sh_wr;
		logic put;
		logic fin;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mode_rem;
		logic scan_end;
		logic less;
		logic refuse;
		logic shift_end;
		logic out_busy;
	} sts_t;

endpackage

>>> rtl/core/sorted_unique_set_core.sv
`timescale 1ns / 1ps
// Sorted set of distinct signed 32-bit values, held ascending in a RAM.
// Input channel (in_valid/in_ready, mode, value): one beat per request,
//   mode 0 inserts value, mode 1 removes it.
// Output channel (out_valid/out_ready, status, entry_count): exactly one beat
//   per request. status: done, duplicate, not present, or store full;
//   entry_count is the number of held values after the request (low 5 bits).
// One request at a time. The search walks the RAM from the bottom, reading then
// comparing each entry below the value (single read port, registered read data);
// an accepted change then moves each entry from the slot upward (for a remove,
// those above it) one place, by a read and a write each, and an insert finally
// writes the new value into the slot.
// in_ready is high only while the core is idle, which it becomes in the same cycle
// that output valid rises. A finished result sits in an output register, so a
// stalled receiver does not block the next request; the core only waits at the
// end of that next one if the register is still full.
// Reset (arst_n low) empties the set and drops any pending output beat; RAM
// contents need no clearing since only entries below the count are read.
module sorted_unique_set_core
	import sus_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    mode,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [STAT_W-1:0]       status,
	output logic [ECNT_W-1:0]       entry_count
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: search, decide, shift, write, report
	sus_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// entry RAM, count, scan index and output register
	sus_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.entry_count(entry_count)
	);

endmodule

>>> rtl/core/sus_ram.sv
`timescale 1ns / 1ps
module sus_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/core/sus_ctrl.sv
`timescale 1ns / 1ps
module sus_ctrl
	import sus_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SRCH_RD  = 3'd1;
	localparam logic [2:0] S_SRCH_CMP = 3'd2;
	localparam logic [2:0] S_DECIDE   = 3'd3;
	localparam logic [2:0] S_SH_RD    = 3'd4;
	localparam logic [2:0] S_SH_WR    = 3'd5;
	localparam logic [2:0] S_PUT      = 3'd6;
	localparam logic [2:0] S_FIN      = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				cmd.srch_rd = 1'b1;
				state_d     = sts.scan_end ? S_DECIDE : S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
				state_d      = sts.less ? S_SRCH_RD : S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.refuse) begin
					state_d = S_FIN;
				end else begin
					cmd.sh_init = 1'b1;
					state_d     = S_SH_RD;
				end
			end
			S_SH_RD: begin
				if (sts.shift_end) begin
					state_d = sts.mode_rem ? S_FIN : S_PUT;
				end else begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SH_RD;
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/sus_dp.sv
`timescale 1ns / 1ps
module sus_dp
	import sus_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic                    mode,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [STAT_W-1:0]       status,
	output logic [ECNT_W-1:0]       entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic              mode_q;
	logic [VAL_W-1:0]  val_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     pos_q;
	logic              hit_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [ECNT_W-1:0] ecnt_q;

	logic [VAL_W-1:0]  rd_data;
	logic [CW-1:0]     rd_idx;
	logic [CW-1:0]     wr_idx;
	logic              wr_en;
	logic [VAL_W-1:0]  wr_data;
	logic [VAL_W-1:0]  key_in;
	logic [VAL_W-1:0]  key_rd;
	logic [STAT_W-1:0] code;
	logic [CW-1:0]     cnt_next;
	logic [CW:0]       idx_inc;

	// flip sign bit so unsigned compare gives signed order
	assign key_in = {~val_q[VAL_W-1], val_q[VAL_W-2:0]};
	assign key_rd = {~rd_data[VAL_W-1], rd_data[VAL_W-2:0]};
	assign idx_inc = {1'b0, idx_q} + (CW+1)'(1);

	always_comb begin
		if (mode_q == MODE_INSERT) begin
			if (hit_q) begin
				code = STAT_DUP;
			end else if (cnt_q >= CW'(CAPACITY)) begin
				code = STAT_FULL;
			end else begin
				code = STAT_DONE;
			end
		end else begin
			code = hit_q ? STAT_DONE : STAT_ABSENT;
		end
	end

	always_comb begin
		if (code != STAT_DONE) begin
			cnt_next = cnt_q;
		end else if (mode_q == MODE_INSERT) begin
			cnt_next = cnt_q + CW'(1);
		end else begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	assign sts.mode_rem  = (mode_q == MODE_REMOVE);
	assign sts.scan_end  = (idx_q == cnt_q);
	assign sts.less      = (key_rd < key_in);
	assign sts.refuse    = (code != STAT_DONE);
	assign sts.shift_end = (mode_q == MODE_INSERT) ? (idx_q == pos_q)
	                                               : (idx_inc >= {1'b0, cnt_q});
	assign sts.out_busy  = out_valid_q & ~out_ready;

	// read: scan position, or neighbor being moved
	always_comb begin
		if (cmd.sh_rd) begin
			rd_idx = (mode_q == MODE_INSERT) ? (idx_q - CW'(1)) : idx_inc[CW-1:0];
		end else begin
			rd_idx = idx_q;
		end
	end

	assign wr_en   = cmd.sh_wr | cmd.put;
	assign wr_idx  = cmd.put ? pos_q : idx_q;
	assign wr_data = cmd.put ? val_q : rd_data;

	sus_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_idx[AW-1:0]),
		.wr_data(wr_data),
		.rd_addr(rd_idx[AW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			val_q  <= value;
			idx_q  <= '0;
			hit_q  <= 1'b0;
		end
		if (cmd.srch_rd && sts.scan_end) begin
			pos_q <= idx_q;
		end
		if (cmd.srch_cmp) begin
			if (sts.less) begin
				idx_q <= idx_inc[CW-1:0];
			end else begin
				pos_q <= idx_q;
				hit_q <= (rd_data == val_q);
			end
		end
		if (cmd.sh_init) begin
			idx_q <= (mode_q == MODE_INSERT) ? cnt_q : pos_q;
		end
		if (cmd.sh_wr) begin
			idx_q <= (mode_q == MODE_INSERT) ? (idx_q - CW'(1)) : idx_inc[CW-1:0];
		end
		if (cmd.fin) begin
			status_q <= code;
			ecnt_q   <= ECNT_W'(cnt_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = ecnt_q;

endmodule
